FILE: rtl/kog_pkg.sv
// kog_pkg: shared constants and types of the k-mer overlap graph block
// no dependencies; used by the interfaces and every kog module

package kog_pkg;

    localparam int ENTRIES      = 32;
    localparam int MAX_KMER_LEN = 32;
    localparam int IDX_W        = 5;
    localparam int KMER_W       = 64;
    localparam int CNT_W        = 6;
    localparam int LEN_W        = 6;
    localparam int CFG_AW       = 2;
    localparam int FIFO_DEPTH   = 2;
    localparam int FIFO_AW      = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW      = $clog2(FIFO_DEPTH + 1);

    localparam logic [CFG_AW-1:0] REG_ENTRY_COUNT = CFG_AW'(0);
    localparam logic [CFG_AW-1:0] REG_KMER_LEN    = CFG_AW'(1);

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_QUERY = 2'd1,
        KIND_MISS  = 2'd2
    } t_kind;

    // one classified word handed from the front to the back
    typedef struct packed {
        t_kind              kind;
        logic [IDX_W-1:0]   idx;
        logic [KMER_W-1:0]  kmer;
        logic [IDX_W-1:0]   last_j;
        logic [LEN_W-1:0]   len;
    } t_cmd;

endpackage

FILE: rtl/kog_if.sv
// kog_if: valid/ready channel interfaces of the k-mer overlap graph block
// depends on kog_pkg

interface kog_in_if;
    import kog_pkg::*;
    logic              valid;
    logic              ready;
    logic              op;
    logic [IDX_W-1:0]  index;
    logic [KMER_W-1:0] kmer;
    modport source (output valid, op, index, kmer, input ready);
    modport sink   (input valid, op, index, kmer, output ready);
endinterface

interface kog_out_if;
    import kog_pkg::*;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] source_index;
    logic [IDX_W-1:0] target_index;
    logic             found;
    logic             last;
    modport source (output valid, source_index, target_index, found, last, input ready);
    modport sink   (input valid, source_index, target_index, found, last, output ready);
endinterface

interface kog_cfg_if;
    import kog_pkg::*;
    logic              valid;
    logic              ready;
    logic [CFG_AW-1:0] index;
    logic [CNT_W-1:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/kog_fifo.sv
// kog_fifo: short command queue between front and back
// depends on kog_pkg

module kog_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  kog_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output kog_pkg::t_cmd o_cmd,
    output logic          o_empty
);
    import kog_pkg::*;

    t_cmd               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wp;
    logic [FIFO_AW-1:0] r_rp;
    logic [FIFO_CW-1:0] r_cnt;

    assign o_full  = (r_cnt == FIFO_CW'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/kog_front.sv
// kog_front: configuration registers and input classification
// depends on kog_pkg and kog_if; feeds kog_fifo

module kog_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    kog_in_if.sink        i_in,
    kog_cfg_if.sink       i_cfg,
    input  logic          i_full,
    output logic          o_push,
    output kog_pkg::t_cmd o_cmd
);
    import kog_pkg::*;

    logic [CNT_W-1:0] r_entry_count;
    logic [LEN_W-1:0] r_kmer_len;
    logic [CNT_W-1:0] eff_count;
    logic [LEN_W-1:0] eff_len;
    logic             in_range;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= CNT_W'(1);
            r_kmer_len    <= LEN_W'(2);
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_ENTRY_COUNT: r_entry_count <= i_cfg.data;
                REG_KMER_LEN:    r_kmer_len    <= LEN_W'(i_cfg.data);
                default: ;
            endcase
        end
    end

    always_comb begin
        eff_count = (r_entry_count > CNT_W'(ENTRIES)) ? CNT_W'(ENTRIES) : r_entry_count;
        if (r_kmer_len < LEN_W'(2)) begin
            eff_len = LEN_W'(2);
        end else if (r_kmer_len > LEN_W'(MAX_KMER_LEN)) begin
            eff_len = LEN_W'(MAX_KMER_LEN);
        end else begin
            eff_len = r_kmer_len;
        end
        in_range = ({1'b0, i_in.index} < eff_count);
    end

    assign i_in.ready = !i_full;

    always_comb begin
        o_cmd.idx    = i_in.index;
        o_cmd.kmer   = i_in.kmer;
        o_cmd.len    = eff_len;
        // only used for in-range queries, where the count is at least one
        o_cmd.last_j = IDX_W'(eff_count - 1'b1);
        if (i_in.op == OP_LOAD) begin
            o_cmd.kind = KIND_LOAD;
        end else if (in_range) begin
            o_cmd.kind = KIND_QUERY;
        end else begin
            o_cmd.kind = KIND_MISS;
        end
        // out-of-range loads are dropped here
        o_push = i_in.valid && !i_full && !(i_in.op == OP_LOAD && !in_range);
    end

endmodule

FILE: rtl/kog_back.sv
// kog_back: k-mer table, overlap scan and result register
// depends on kog_pkg and kog_if; drains kog_fifo

module kog_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  kog_pkg::t_cmd i_cmd,
    input  logic          i_empty,
    output logic          o_pop,
    kog_out_if.source     o_out
);
    import kog_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SRC  = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_FIN  = 4'b1000
    } t_state;

    logic [KMER_W-1:0] r_mem [ENTRIES];
    logic [KMER_W-1:0] r_rd_data;

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_src, n_src;
    logic [IDX_W-1:0]  r_last_j, n_last_j;
    logic [IDX_W-1:0]  r_j, n_j;
    logic [IDX_W-1:0]  r_pend_j, n_pend_j;
    logic              r_have_pend, n_have_pend;
    logic [KMER_W-1:0] r_mask, n_mask;
    logic [KMER_W-1:0] r_suffix, n_suffix;

    logic              r_ov;
    logic [IDX_W-1:0]  r_o_src;
    logic [IDX_W-1:0]  r_o_tgt;
    logic              r_o_found;
    logic              r_o_last;

    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic              out_free;
    logic              match;
    logic              emit;
    logic [IDX_W-1:0]  e_src;
    logic [IDX_W-1:0]  e_tgt;
    logic              e_found;
    logic              e_last;

    // low 2*(len-1) bits set
    function automatic logic [KMER_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
        logic [LEN_W:0] sh;
        sh = {len - 1'b1, 1'b0};
        return (KMER_W'(1) << sh) - KMER_W'(1);
    endfunction

    assign out_free = !r_ov || o_out.ready;
    assign match    = ((r_rd_data & r_mask) == r_suffix) && (r_j != r_src);

    always_comb begin
        n_state     = r_state;
        n_src       = r_src;
        n_last_j    = r_last_j;
        n_j         = r_j;
        n_pend_j    = r_pend_j;
        n_have_pend = r_have_pend;
        n_mask      = r_mask;
        n_suffix    = r_suffix;
        rd_addr     = r_j;
        wr_en       = 1'b0;
        o_pop       = 1'b0;
        emit        = 1'b0;
        e_src       = r_src;
        e_tgt       = '0;
        e_found     = 1'b0;
        e_last      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                rd_addr = i_cmd.idx;
                if (!i_empty) begin
                    unique case (i_cmd.kind)
                        KIND_LOAD: begin
                            o_pop = 1'b1;
                            wr_en = 1'b1;
                        end
                        KIND_QUERY: begin
                            o_pop    = 1'b1;
                            n_src    = i_cmd.idx;
                            n_last_j = i_cmd.last_j;
                            n_mask   = prefix_mask(i_cmd.len);
                            n_state  = ST_SRC;
                        end
                        KIND_MISS: begin
                            if (out_free) begin
                                o_pop  = 1'b1;
                                emit   = 1'b1;
                                e_src  = i_cmd.idx;
                                e_last = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_SRC: begin
                n_suffix    = (r_rd_data >> 2) & r_mask;
                rd_addr     = '0;
                n_j         = '0;
                n_have_pend = 1'b0;
                n_state     = ST_SCAN;
            end
            ST_SCAN: begin
                // a held match is sent once the next one shows it was not the last
                if (!(match && r_have_pend && !out_free)) begin
                    if (match) begin
                        if (r_have_pend) begin
                            emit    = 1'b1;
                            e_tgt   = r_pend_j;
                            e_found = 1'b1;
                        end
                        n_pend_j    = r_j;
                        n_have_pend = 1'b1;
                    end
                    if (r_j == r_last_j) begin
                        n_state = ST_FIN;
                    end else begin
                        n_j     = r_j + 1'b1;
                        rd_addr = r_j + 1'b1;
                    end
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    emit    = 1'b1;
                    e_tgt   = r_have_pend ? r_pend_j : '0;
                    e_found = r_have_pend;
                    e_last  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[i_cmd.idx] <= i_cmd.kmer;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_have_pend <= 1'b0;
            r_ov        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_have_pend <= n_have_pend;
            if (emit) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_src    <= n_src;
        r_last_j <= n_last_j;
        r_j      <= n_j;
        r_pend_j <= n_pend_j;
        r_mask   <= n_mask;
        r_suffix <= n_suffix;
        if (emit) begin
            r_o_src   <= e_src;
            r_o_tgt   <= e_tgt;
            r_o_found <= e_found;
            r_o_last  <= e_last;
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.source_index = r_o_src;
    assign o_out.target_index = r_o_tgt;
    assign o_out.found        = r_o_found;
    assign o_out.last         = r_o_last;

endmodule

FILE: rtl/kmer_overlap_graph.sv
// kmer_overlap_graph: back end handles a load or an out-of-range query in its idle state
// and walks an in-range query through source read, scan (one table read a cycle unless a
// result stalls) and finish states; it takes a new command only once back in idle
// reset (synchronous, active low) sets entry_count = 1, kmer_len = 2 and empties
// the queue; the k-mer table is not cleared, entries are undefined until loaded
// depends on kog_pkg, kog_if, kog_fifo, kog_front, kog_back

module kmer_overlap_graph (
    input  logic      i_clk,
    input  logic      i_rst_n,
    kog_in_if.sink    i_in,
    kog_cfg_if.sink   i_cfg,
    kog_out_if.source o_out
);
    import kog_pkg::*;

    t_cmd w_push_cmd;
    t_cmd w_pop_cmd;
    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_empty;

    kog_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (i_cfg),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_cmd   (w_push_cmd)
    );

    kog_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_cmd   (w_pop_cmd),
        .o_empty (w_empty)
    );

    kog_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_pop_cmd),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

`ifndef ASSERT_OFF
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("queue written while full");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("queue read while empty");

    a_miss_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.found) |-> (o_out.last && o_out.target_index == '0))
        else $error("empty result not final or has a target");

    a_no_self_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.found) |-> (o_out.source_index != o_out.target_index))
        else $error("edge from an entry to itself");
`endif

endmodule
